/* sv/tst_pkg.sv */
`default_nettype none

package tst_pkg;

  // request kinds carried on the input tuser
  localparam logic [2:0] KIND_REGISTER = 3'd0;
  localparam logic [2:0] KIND_QUERY    = 3'd1;
  localparam logic [2:0] KIND_REMOVE   = 3'd2;
  localparam logic [2:0] KIND_TICK     = 3'd3;
  localparam logic [2:0] KIND_DISPATCH = 3'd4;

  localparam int unsigned HandleW = 16;
  localparam int unsigned TicksW  = 15;

  // program steps of the sequencer
  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_READ,
    STEP_EVAL,
    STEP_FINAL
  } step_e;

  // jump conditions of a control word
  typedef enum logic [1:0] {
    JC_GO,
    JC_REQ,
    JC_SCAN,
    JC_OUT
  } jump_e;

  // one control word
  typedef struct packed {
    logic  in_ready;
    logic  mem_rd;
    logic  eval;
    logic  fin;
    jump_e jc;
    step_e target;
    step_e alt;
  } ctrl_t;

  // status from the datapath that steers the jumps
  typedef struct packed {
    logic accept;
    logic kind_known;
    logic stall;
    logic scan_end;
    logic out_free;
  } seq_stat_t;

  // program rom
  function automatic ctrl_t ucode(step_e step);
    ctrl_t w;
    w = '{in_ready: 1'b0, mem_rd: 1'b0, eval: 1'b0, fin: 1'b0,
          jc: JC_GO, target: STEP_IDLE, alt: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.in_ready = 1'b1;
        w.jc       = JC_REQ;
        w.target   = STEP_READ;
        w.alt      = STEP_FINAL;
      end
      STEP_READ: begin
        w.mem_rd = 1'b1;
        w.jc     = JC_GO;
        w.target = STEP_EVAL;
      end
      STEP_EVAL: begin
        w.eval   = 1'b1;
        w.jc     = JC_SCAN;
        w.target = STEP_READ;
        w.alt    = STEP_FINAL;
      end
      STEP_FINAL: begin
        w.fin    = 1'b1;
        w.jc     = JC_OUT;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jc     = JC_GO;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* sv/timer_slot_table.sv */
`default_nettype none

// channel   dir  width     contents
// s_axis    in   tuser 3   kind
//                tdata 32  handle, delay
// m_axis    out  tdata 24  ok, fired, fired_handle, wake
//                tlast     last result of the request
//
// a request visits the slots from the top down, then ends in a final step:
// the slot memory has one port with a registered read, so each slot is read
// in one step and evaluated in the next. register, query and remove stop at
// the first match. reset clears one valid bit per slot, no clearing pass.
// a full output register stalls the final step, and eval of a second expired slot.

module timer_slot_table #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // handle[15:0], delay[30:16], zero
  input  wire logic [2:0]  s_axis_tuser,  // kind[2:0]
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,  // ok, fired, fired_handle[17:2], wake, zero
  output      logic        m_axis_tlast
);

  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned HW    = tst_pkg::HandleW;
  localparam int unsigned TW    = tst_pkg::TicksW;
  localparam int unsigned WordW = HW + TW;

  tst_pkg::ctrl_t     ctrl;
  tst_pkg::seq_stat_t stat;

  // request registers
  logic [2:0]      kind_q;
  logic [HW-1:0]   req_handle_q;
  logic [TW-1:0]   req_delay_q;
  logic [IdxW-1:0] idx_q;
  logic            flag_q;
  logic            pend_q;
  logic [HW-1:0]   pend_handle_q;

  // slot memory with one valid bit per slot
  logic [WordW-1:0] mem_q [SLOTS];
  logic [SLOTS-1:0] valid_q;
  logic [WordW-1:0] rd_word_q;
  logic             rd_valid_q;

  logic            accept;
  logic            kind_known;
  logic            out_free;
  logic [HW-1:0]   rd_h;
  logic [TW-1:0]   rd_t;
  logic            wr_en;
  logic [WordW-1:0] wr_word;
  logic            brk;
  logic            flag_set;
  logic            fire;
  logic            stall;
  logic            scan_end;
  logic            emit;
  logic            emit_ok;
  logic            emit_fired;
  logic [HW-1:0]   emit_handle;
  logic            emit_wake;
  logic            emit_last;

  logic            out_valid_q;
  logic            out_ok_q;
  logic            out_fired_q;
  logic [HW-1:0]   out_handle_q;
  logic            out_wake_q;
  logic            out_last_q;

  tst_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign s_axis_tready = ctrl.in_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign kind_known    = (s_axis_tuser == tst_pkg::KIND_REGISTER) ||
                         (s_axis_tuser == tst_pkg::KIND_QUERY) ||
                         (s_axis_tuser == tst_pkg::KIND_REMOVE) ||
                         (s_axis_tuser == tst_pkg::KIND_TICK) ||
                         (s_axis_tuser == tst_pkg::KIND_DISPATCH);
  assign out_free      = !out_valid_q || m_axis_tready;

  // slot contents, a slot never written reads as free with zero ticks
  assign rd_h = rd_valid_q ? rd_word_q[WordW-1:TW] : '0;
  assign rd_t = rd_valid_q ? rd_word_q[TW-1:0] : '0;

  // per-slot evaluation by request kind
  always_comb begin
    wr_en    = 1'b0;
    wr_word  = {rd_h, rd_t};
    brk      = 1'b0;
    flag_set = 1'b0;
    fire     = 1'b0;
    case (kind_q)
      tst_pkg::KIND_REGISTER: begin
        if (rd_h == '0) begin
          wr_en    = 1'b1;
          wr_word  = {req_handle_q, req_delay_q};
          brk      = 1'b1;
          flag_set = 1'b1;
        end
      end
      tst_pkg::KIND_QUERY: begin
        if (rd_h == req_handle_q) begin
          brk      = 1'b1;
          flag_set = 1'b1;
        end
      end
      tst_pkg::KIND_REMOVE: begin
        if (rd_h == req_handle_q) begin
          wr_en    = 1'b1;
          wr_word  = {{HW{1'b0}}, rd_t};
          brk      = 1'b1;
          flag_set = 1'b1;
        end
      end
      tst_pkg::KIND_TICK: begin
        if (rd_t != '0) begin
          wr_en   = 1'b1;
          wr_word = {rd_h, rd_t - TW'(1)};
        end else if (rd_h != '0) begin
          flag_set = 1'b1;
        end
      end
      tst_pkg::KIND_DISPATCH: begin
        if (rd_h != '0 && rd_t == '0) begin
          wr_en   = 1'b1;
          wr_word = {{HW{1'b0}}, rd_t};
          fire    = 1'b1;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // a second expired slot pushes out the one held back
  assign stall    = ctrl.eval && fire && pend_q && !out_free;
  assign scan_end = brk || (idx_q == '0);

  assign stat = '{accept: accept, kind_known: kind_known, stall: stall,
                  scan_end: scan_end, out_free: out_free};

  // result to emit this cycle
  always_comb begin
    emit        = 1'b0;
    emit_ok     = 1'b0;
    emit_fired  = 1'b0;
    emit_handle = '0;
    emit_wake   = 1'b0;
    emit_last   = 1'b0;
    if (ctrl.eval && fire && pend_q && out_free) begin
      emit        = 1'b1;
      emit_fired  = 1'b1;
      emit_handle = pend_handle_q;
    end else if (ctrl.fin && out_free) begin
      emit      = 1'b1;
      emit_last = 1'b1;
      case (kind_q)
        tst_pkg::KIND_REGISTER,
        tst_pkg::KIND_QUERY,
        tst_pkg::KIND_REMOVE: begin
          emit_ok = flag_q;
        end
        tst_pkg::KIND_TICK: begin
          emit_wake = flag_q;
        end
        tst_pkg::KIND_DISPATCH: begin
          emit_fired  = pend_q;
          emit_handle = pend_q ? pend_handle_q : '0;
        end
        default: begin
          emit_ok = 1'b0;
        end
      endcase
    end
  end

  // request capture, scan index and running flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= tst_pkg::KIND_REGISTER;
      idx_q  <= '0;
      flag_q <= 1'b0;
      pend_q <= 1'b0;
    end else if (accept) begin
      kind_q <= s_axis_tuser;
      idx_q  <= IdxW'(SLOTS - 1);
      flag_q <= 1'b0;
      pend_q <= 1'b0;
    end else if (ctrl.eval && !stall) begin
      if (flag_set) begin
        flag_q <= 1'b1;
      end
      if (fire) begin
        pend_q <= 1'b1;
      end
      if (!scan_end) begin
        idx_q <= idx_q - IdxW'(1);
      end
    end
  end

  // request payload and held-back expired handle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_handle_q <= s_axis_tdata[15:0];
      req_delay_q  <= s_axis_tdata[30:16];
    end
    if (ctrl.eval && !stall && fire) begin
      pend_handle_q <= rd_h;
    end
  end

  // slot memory write and registered read
  always_ff @(posedge clk_i) begin
    if (ctrl.eval && !stall && wr_en) begin
      mem_q[idx_q] <= wr_word;
    end
    if (ctrl.mem_rd) begin
      rd_word_q <= mem_q[idx_q];
    end
  end

  // valid bits of the slot memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl.eval && !stall && wr_en) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (ctrl.mem_rd) begin
        rd_valid_q <= valid_q[idx_q];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_ok_q     <= emit_ok;
      out_fired_q  <= emit_fired;
      out_handle_q <= emit_handle;
      out_wake_q   <= emit_wake;
      out_last_q   <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_wake_q, out_handle_q, out_fired_q, out_ok_q};
  assign m_axis_tlast  = out_last_q;

  // checks on the sequencer and datapath
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind_known |=> idx_q == IdxW'(SLOTS - 1))
    else $error("scan does not start at the top slot");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result written over a waiting result");

  a_pend_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> kind_q == tst_pkg::KIND_DISPATCH)
    else $error("held-back handle outside a dispatch");

  a_final_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.fin && out_free |=> s_axis_tready)
    else $error("sequencer not back to idle after final result");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.in_ready |-> !(ctrl.eval || ctrl.fin || ctrl.mem_rd))
    else $error("datapath active while waiting for a request");

endmodule

`default_nettype wire

/* sv/tst_seq.sv */
`default_nettype none

module tst_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tst_pkg::seq_stat_t stat_i,
  output tst_pkg::ctrl_t         ctrl_o
);

  tst_pkg::step_e step_q, step_d;
  tst_pkg::ctrl_t ctrl;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= tst_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // rom fetch
  assign ctrl = tst_pkg::ucode(step_q);

  // conditional jump
  always_comb begin
    step_d = step_q;
    case (ctrl.jc)
      tst_pkg::JC_GO: begin
        step_d = ctrl.target;
      end
      tst_pkg::JC_REQ: begin
        if (stat_i.accept) begin
          step_d = stat_i.kind_known ? ctrl.target : ctrl.alt;
        end
      end
      tst_pkg::JC_SCAN: begin
        if (!stat_i.stall) begin
          step_d = stat_i.scan_end ? ctrl.alt : ctrl.target;
        end
      end
      tst_pkg::JC_OUT: begin
        if (stat_i.out_free) begin
          step_d = ctrl.target;
        end
      end
      default: begin
        step_d = tst_pkg::STEP_IDLE;
      end
    endcase
  end

  assign ctrl_o = ctrl;

endmodule

`default_nettype wire

/* dv/timer_slot_table_chk.sv */
`timescale 1ns / 1ps

module timer_slot_table_chk #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  input  wire logic        req_ready_i,
  input  wire logic [31:0] req_data_i,   // handle[15:0], delay[30:16], zero
  input  wire logic [2:0]  req_kind_i,   // kind[2:0]
  input  wire logic        rsp_valid_i,
  input  wire logic        rsp_ready_i,
  input  wire logic [23:0] rsp_data_i,   // ok, fired, fired_handle[17:2], wake, zero
  input  wire logic        rsp_last_i,
  output int               err_cnt_o,
  output int               due_cnt_o,
  output int               rsp_cnt_o,
  output int               fire_cnt_o
);

  localparam int          MaxPrinted = 40;
  localparam int unsigned HW         = tst_pkg::HandleW;
  localparam int unsigned TW         = tst_pkg::TicksW;

  typedef struct packed {
    logic           ok;
    logic           fired;
    logic [HW-1:0]  fired_hnd;
    logic           wake;
    logic           last;
  } slot_rsp_t;

  // own copy of the timer table
  logic [HW-1:0] slot_hnd   [SLOTS];
  logic [TW-1:0] slot_ticks [SLOTS];

  slot_rsp_t rsp_due_q [$];
  int        err_cnt;
  int        rsp_cnt;
  int        fire_cnt;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_cnt < MaxPrinted) begin
      $display("%0t: result %0d, %s: got %0h, want %0h", $time, rsp_cnt, what, got, want);
    end
    err_cnt++;
  endtask

  // apply one request to the table and queue the results it causes
  task automatic apply_request(input logic [2:0] kind, input logic [HW-1:0] hnd,
                               input logic [TW-1:0] dly);
    logic          hit;
    int            n;
    logic [HW-1:0] freed [SLOTS];
    hit = 1'b0;
    n   = 0;
    case (kind)
      tst_pkg::KIND_REGISTER: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (slot_hnd[i] == '0) begin
            slot_ticks[i] = dly;
            slot_hnd[i]   = hnd;
            hit           = 1'b1;
            break;
          end
        end
        rsp_due_q.push_back('{ok: hit, fired: 1'b0, fired_hnd: '0, wake: 1'b0, last: 1'b1});
      end
      tst_pkg::KIND_QUERY, tst_pkg::KIND_REMOVE: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (slot_hnd[i] == hnd) begin
            if (kind == tst_pkg::KIND_REMOVE) slot_hnd[i] = '0;
            hit = 1'b1;
            break;
          end
        end
        rsp_due_q.push_back('{ok: hit, fired: 1'b0, fired_hnd: '0, wake: 1'b0, last: 1'b1});
      end
      tst_pkg::KIND_TICK: begin
        // wake only from an occupied slot that was already at zero
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (slot_ticks[i] != '0) begin
            slot_ticks[i] = slot_ticks[i] - TW'(1);
          end else if (slot_hnd[i] != '0) begin
            hit = 1'b1;
          end
        end
        rsp_due_q.push_back('{ok: 1'b0, fired: 1'b0, fired_hnd: '0, wake: hit, last: 1'b1});
      end
      tst_pkg::KIND_DISPATCH: begin
        // free expired slots from high to low
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (slot_hnd[i] != '0 && slot_ticks[i] == '0) begin
            freed[n]    = slot_hnd[i];
            slot_hnd[i] = '0;
            n++;
          end
        end
        if (n == 0) begin
          rsp_due_q.push_back('{ok: 1'b0, fired: 1'b0, fired_hnd: '0, wake: 1'b0, last: 1'b1});
        end
        for (int j = 0; j < n; j++) begin
          rsp_due_q.push_back('{ok: 1'b0, fired: 1'b1, fired_hnd: freed[j], wake: 1'b0,
                                last: (j == n - 1)});
        end
      end
      default: begin
        rsp_due_q.push_back('{ok: 1'b0, fired: 1'b0, fired_hnd: '0, wake: 1'b0, last: 1'b1});
      end
    endcase
  endtask

  // compare each result with the oldest expectation, then take in new requests
  always @(posedge clk_i or negedge rst_ni) begin
    slot_rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_hnd[i]   = '0;
        slot_ticks[i] = '0;
      end
      rsp_due_q.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (rsp_due_q.size() == 0) begin
          report_mismatch("result with none due", int'(rsp_data_i), 0);
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp_data_i[0] != want.ok) begin
            report_mismatch("ok", int'(rsp_data_i[0]), int'(want.ok));
          end
          if (rsp_data_i[1] != want.fired) begin
            report_mismatch("fired", int'(rsp_data_i[1]), int'(want.fired));
          end
          if (rsp_data_i[17:2] != want.fired_hnd) begin
            report_mismatch("fired_handle", int'(rsp_data_i[17:2]), int'(want.fired_hnd));
          end
          if (rsp_data_i[18] != want.wake) begin
            report_mismatch("wake", int'(rsp_data_i[18]), int'(want.wake));
          end
          if (rsp_data_i[23:19] != '0) begin
            report_mismatch("padding", int'(rsp_data_i[23:19]), 0);
          end
          if (rsp_last_i != want.last) begin
            report_mismatch("last", int'(rsp_last_i), int'(want.last));
          end
          if (want.fired) fire_cnt++;
        end
        rsp_cnt++;
      end
      if (req_valid_i && req_ready_i) begin
        apply_request(req_kind_i, req_data_i[15:0], req_data_i[30:16]);
      end
    end
    err_cnt_o  <= err_cnt;
    due_cnt_o  <= rsp_due_q.size();
    rsp_cnt_o  <= rsp_cnt;
    fire_cnt_o <= fire_cnt;
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SLOTS     = 8;
  localparam int          KindCodes = 8;
  localparam int          IdlePct   = 12;
  localparam int          RandReqs  = 450;
  localparam int          DrainWait = 4 * SLOTS + 8;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // handle[15:0], delay[30:16], zero
  logic [2:0]  s_axis_tuser  = '0;  // kind[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // ok, fired, fired_handle[17:2], wake, zero
  logic        m_axis_tlast;

  logic quiet = 1'b0;
  int   err_cnt;
  int   due_cnt;
  int   rsp_cnt;
  int   fire_cnt;
  int   kind_cnt [KindCodes];

  always #6 clk_i = ~clk_i;

  timer_slot_table #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  timer_slot_table_chk #(
    .SLOTS(SLOTS)
  ) i_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_kind_i  (s_axis_tuser),
    .rsp_valid_i (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_data_i  (m_axis_tdata),
    .rsp_last_i  (m_axis_tlast),
    .err_cnt_o   (err_cnt),
    .due_cnt_o   (due_cnt),
    .rsp_cnt_o   (rsp_cnt),
    .fire_cnt_o  (fire_cnt)
  );

  // result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IdlePct);
  end

  // one request, with random gaps ahead of it
  task automatic push_request(input logic [2:0] kind, input logic [15:0] hnd,
                              input logic [14:0] dly);
    while (!quiet && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, dly, hnd};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    kind_cnt[kind]++;
  endtask

  // hold the sender until every due result is out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_cnt != 0) @(posedge clk_i);
  endtask

  initial begin
    int          pick;
    logic [2:0]  kind;
    logic [15:0] hnd;
    logic [14:0] dly;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, full table, handle zero, unknown kinds
    push_request(tst_pkg::KIND_DISPATCH, 16'h1234, 15'h0);
    push_request(tst_pkg::KIND_TICK, 16'h0, 15'h0);
    push_request(tst_pkg::KIND_REGISTER, 16'hFFFF, 15'h7FFF);
    push_request(tst_pkg::KIND_REGISTER, 16'h0001, 15'h0);
    push_request(tst_pkg::KIND_REGISTER, 16'h8000, 15'h1);
    push_request(tst_pkg::KIND_QUERY, 16'hFFFF, 15'h7FFF);
    push_request(tst_pkg::KIND_QUERY, 16'h0002, 15'h0);
    push_request(tst_pkg::KIND_TICK, 16'hFFFF, 15'h7FFF);
    push_request(tst_pkg::KIND_DISPATCH, 16'h0, 15'h0);
    push_request(tst_pkg::KIND_REGISTER, 16'h0002, 15'h3);
    for (int h = 3; h <= 8; h++) push_request(tst_pkg::KIND_REGISTER, 16'(h), 15'h0);
    push_request(tst_pkg::KIND_REGISTER, 16'h0009, 15'h2);
    push_request(tst_pkg::KIND_QUERY, 16'h0, 15'h0);
    push_request(tst_pkg::KIND_REMOVE, 16'h0005, 15'h0);
    push_request(tst_pkg::KIND_REMOVE, 16'h0005, 15'h0);
    push_request(tst_pkg::KIND_QUERY, 16'h0, 15'h0);
    push_request(tst_pkg::KIND_REMOVE, 16'h0, 15'h0);
    push_request(tst_pkg::KIND_REGISTER, 16'h0, 15'h5);
    push_request(tst_pkg::KIND_TICK, 16'h0, 15'h0);
    push_request(tst_pkg::KIND_DISPATCH, 16'h0, 15'h0);
    for (int k = int'(tst_pkg::KIND_DISPATCH) + 1; k < KindCodes; k++) begin
      push_request(3'(k), 16'($urandom), 15'($urandom));
    end
    drain_results();

    // random: small handle pool and short delays so slots fill, expire and fire
    for (int n = 0; n < RandReqs; n++) begin
      quiet <= (n >= 150 && n < 250);
      pick = $urandom_range(0, 99);
      if (pick < 30)       kind = tst_pkg::KIND_REGISTER;
      else if (pick < 45)  kind = tst_pkg::KIND_QUERY;
      else if (pick < 60)  kind = tst_pkg::KIND_REMOVE;
      else if (pick < 82)  kind = tst_pkg::KIND_TICK;
      else if (pick < 98)  kind = tst_pkg::KIND_DISPATCH;
      else begin
        kind = 3'($urandom_range(int'(tst_pkg::KIND_DISPATCH) + 1, KindCodes - 1));
      end
      pick = $urandom_range(0, 9);
      if (pick == 0)       hnd = 16'($urandom);
      else if (pick == 1)  hnd = $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
      else                 hnd = 16'($urandom_range(1, 12));
      pick = $urandom_range(0, 9);
      if (pick == 0)       dly = 15'($urandom);
      else if (pick == 1)  dly = 15'h7FFF;
      else                 dly = 15'($urandom_range(0, 5));
      push_request(kind, hnd, dly);
      if (n % 97 == 50) drain_results();
    end
    quiet <= 1'b0;

    drain_results();
    repeat (DrainWait) @(posedge clk_i);

    $display("requests: %0d register, %0d query, %0d remove, %0d tick, %0d dispatch",
             kind_cnt[tst_pkg::KIND_REGISTER], kind_cnt[tst_pkg::KIND_QUERY],
             kind_cnt[tst_pkg::KIND_REMOVE], kind_cnt[tst_pkg::KIND_TICK],
             kind_cnt[tst_pkg::KIND_DISPATCH]);
    $display("%0d results checked, %0d expired handles fired, %0d mismatches",
             rsp_cnt, fire_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("timeout with %0d results still due", due_cnt);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
sv/tst_pkg.sv
sv/tst_seq.sv
sv/timer_slot_table.sv
dv/timer_slot_table_chk.sv
dv/tb.sv
